### hdl/bdph_pkg.sv
package bdph_pkg;

    localparam int CFG_TICK_W = 16;
    localparam int CFG_CODE_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int KIND_W     = 2;

    localparam logic [CFG_IDX_W-1:0] IDX_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_LONGPRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_PRESS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_BUMP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_HOLD      = 3'd4;

    localparam logic [CFG_TICK_W-1:0] RST_DEBOUNCE  = 16'd50;
    localparam logic [CFG_TICK_W-1:0] RST_LONGPRESS = 16'd1000;
    localparam logic [CFG_CODE_W-1:0] RST_PRESS     = 8'd0;
    localparam logic [CFG_CODE_W-1:0] RST_BUMP      = 8'd1;
    localparam logic [CFG_CODE_W-1:0] RST_HOLD      = 8'd2;

    localparam logic [KIND_W-1:0] KIND_PRESS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUMP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOLD  = 2'd2;

    typedef struct packed {
        logic [CFG_TICK_W-1:0] debounce_ticks;
        logic [CFG_TICK_W-1:0] longpress_ticks;
        logic [CFG_CODE_W-1:0] press_code;
        logic [CFG_CODE_W-1:0] bump_code;
        logic [CFG_CODE_W-1:0] hold_code;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [KIND_W-1:0]     kind;
        logic [CFG_CODE_W-1:0] code;
    } t_event;

endpackage

### hdl/bdph_core.sv
module bdph_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_pin_level,
    input  bdph_pkg::t_cfg  i_cfg,
    output bdph_pkg::t_event o_event
);
    import bdph_pkg::*;

    localparam int CW = (COUNT_BITS > CFG_TICK_W) ? COUNT_BITS : CFG_TICK_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  r_stable;
    logic [COUNT_BITS-1:0] r_lock;
    logic [COUNT_BITS-1:0] r_age;
    logic                  n_stable;
    logic [COUNT_BITS-1:0] n_lock;
    logic [COUNT_BITS-1:0] n_age;

    logic                  sample_pressed;
    logic [COUNT_BITS-1:0] age_inc;
    logic [COUNT_BITS-1:0] lock_dec;
    logic                  check;
    logic                  fire;
    logic [CW-1:0]         deb_w;
    logic [COUNT_BITS-1:0] deb_sat;
    logic                  is_hold;

    always_comb begin
        sample_pressed = ~i_pin_level;
        age_inc  = (r_stable && r_age != CNT_MAX) ? r_age + 1'b1 : r_age;
        lock_dec = (r_lock == '0) ? '0 : r_lock - 1'b1;
        check    = (r_lock == '0) || (lock_dec == '0);
        fire     = check && (sample_pressed != r_stable);
        deb_w    = CW'(i_cfg.debounce_ticks);
        deb_sat  = (deb_w > CW'(CNT_MAX)) ? CNT_MAX : deb_w[COUNT_BITS-1:0];
        is_hold  = CW'(age_inc) > CW'(i_cfg.longpress_ticks);
    end

    always_comb begin
        n_stable = r_stable;
        n_lock   = lock_dec;
        n_age    = age_inc;
        if (fire) begin
            n_lock   = deb_sat;
            n_stable = sample_pressed;
            if (sample_pressed) begin
                n_age = '0;
            end
        end
    end

    always_comb begin
        o_event.valid = i_accept && fire;
        if (sample_pressed) begin
            o_event.kind = KIND_PRESS;
            o_event.code = i_cfg.press_code;
        end else if (is_hold) begin
            o_event.kind = KIND_HOLD;
            o_event.code = i_cfg.hold_code;
        end else begin
            o_event.kind = KIND_BUMP;
            o_event.code = i_cfg.bump_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_lock   <= '0;
            r_age    <= '0;
        end else if (i_accept) begin
            r_stable <= n_stable;
            r_lock   <= n_lock;
            r_age    <= n_age;
        end
    end

    a_toggle_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_accept) |=> ((r_stable != $past(r_stable)) == $past(o_event.valid)))
        else $error("stable state changed without an event");

    a_press_clears_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_event.valid && o_event.kind == KIND_PRESS) |=> (r_age == '0))
        else $error("press did not clear press age");

    a_idle_holds_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_accept) |=> ($stable(r_lock) && $stable(r_age)))
        else $error("counters moved without a beat");

    a_release_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.kind != KIND_PRESS) |-> r_stable)
        else $error("release event while released");

endmodule

### hdl/button_debounce_press_hold_unit.sv
// Debounces an active-low button pin sampled once per input beat and reports
// press, short release (bump) and long release (hold) events with configurable
// codes. A new sample can be taken every clock cycle while o_in_stall is low; each
// accepted beat updates the lockout and press-age counters, and at most one event
// is registered into the output register per beat. The output register lets a new
// sample in while an event waits; the input stalls only when that register is
// full and the downstream side stalls. COUNT_BITS sets the counter width;
// lockout lengths above its range saturate. Write configuration only while idle.
module button_debounce_press_hold_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdph_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdph_pkg::CFG_TICK_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_pin_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bdph_pkg::KIND_W-1:0]     o_event_kind,
    output logic [bdph_pkg::CFG_CODE_W-1:0] o_event_code
);
    import bdph_pkg::*;

    t_cfg                  r_cfg;
    t_event                ev;
    logic                  accept;
    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_kind;
    logic [CFG_CODE_W-1:0] r_code;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks  <= RST_DEBOUNCE;
            r_cfg.longpress_ticks <= RST_LONGPRESS;
            r_cfg.press_code      <= RST_PRESS;
            r_cfg.bump_code       <= RST_BUMP;
            r_cfg.hold_code       <= RST_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                IDX_DEBOUNCE:  r_cfg.debounce_ticks  <= i_cfg_data;
                IDX_LONGPRESS: r_cfg.longpress_ticks <= i_cfg_data;
                IDX_PRESS:     r_cfg.press_code      <= i_cfg_data[CFG_CODE_W-1:0];
                IDX_BUMP:      r_cfg.bump_code       <= i_cfg_data[CFG_CODE_W-1:0];
                IDX_HOLD:      r_cfg.hold_code       <= i_cfg_data[CFG_CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bdph_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pin_level (i_pin_level),
        .i_cfg       (r_cfg),
        .o_event     (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= ev.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && ev.valid) begin
            r_kind <= ev.kind;
            r_code <= ev.code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_event_code = r_code;

endmodule
